[src/rsd_pkg.sv]
`default_nettype none

package rsd_pkg;

    localparam int BYTE_W      = 8;
    localparam int K_W         = 3;
    localparam int MAX_RESULTS = 8;
    localparam int IDX_W       = 3;
    localparam int CNT_W       = 4;
    localparam int HEADER_BITS = 3;

    typedef struct packed {
        logic [BYTE_W-1:0] symbol;
        logic              symbol_valid;
        logic              end_of_stream;
        logic              truncated;
    } result_t;

    typedef struct packed {
        logic [CNT_W-1:0]                 count;
        result_t [MAX_RESULTS-1:0]        res;
    } batch_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

endpackage

`default_nettype wire

[src/rsd_front.sv]
`default_nettype none

module rsd_front (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  accept,
    input  wire [7:0]            in_byte,
    input  wire                  last_byte,
    output logic                 batch_push,
    output rsd_pkg::batch_t      batch
);
    import rsd_pkg::*;

    logic              awaiting_header_reg, awaiting_header_next;
    logic [K_W-1:0]    k_reg, k_next;
    logic              in_rem_reg, in_rem_next;
    logic [BYTE_W-1:0] qc_reg, qc_next;
    logic [BYTE_W-1:0] acc_reg, acc_next;
    logic [K_W-1:0]    rem_left_reg, rem_left_next;

    always_comb
    begin
        logic             stopped;
        logic             done;
        logic [CNT_W-1:0] n;
        logic [3:0]       start;

        awaiting_header_next = awaiting_header_reg;
        k_next               = k_reg;
        in_rem_next          = in_rem_reg;
        qc_next              = qc_reg;
        acc_next             = acc_reg;
        rem_left_next        = rem_left_reg;
        start                = '0;
        stopped              = 1'b0;
        n                    = '0;
        batch                = '0;

        // header: three bits, msb first
        if (awaiting_header_reg)
        begin
            k_next        = {in_byte[0], in_byte[1], in_byte[2]};
            in_rem_next   = 1'b0;
            qc_next       = '0;
            acc_next      = '0;
            rem_left_next = '0;
            start         = 4'(HEADER_BITS);
        end

        for (int i = 0; i < BYTE_W; i++)
        begin
            done = 1'b0;
            if (4'(i) >= start && !stopped)
            begin
                if (!in_rem_next)
                begin
                    if (in_byte[i])
                    begin
                        qc_next = qc_next + 8'd1;
                    end
                    else
                    begin
                        acc_next = qc_next << k_next;
                        if (k_next == '0)
                        begin
                            done = 1'b1;
                        end
                        else
                        begin
                            in_rem_next   = 1'b1;
                            rem_left_next = k_next;
                        end
                    end
                end
                else
                begin
                    if (rem_left_next != '0)
                    begin
                        rem_left_next = rem_left_next - 3'd1;
                        acc_next      = acc_next | (8'(in_byte[i]) << rem_left_next);
                    end
                    done = (rem_left_next == '0);
                end
            end
            if (done)
            begin
                batch.res[n[IDX_W-1:0]].symbol        = acc_next;
                batch.res[n[IDX_W-1:0]].symbol_valid  = 1'b1;
                batch.res[n[IDX_W-1:0]].end_of_stream = 1'b0;
                batch.res[n[IDX_W-1:0]].truncated     = 1'b0;
                n             = n + 4'd1;
                in_rem_next   = 1'b0;
                qc_next       = '0;
                acc_next      = '0;
                rem_left_next = '0;
                if (last_byte)
                begin
                    stopped = 1'b1;
                end
            end
        end

        awaiting_header_next = 1'b0;

        // closing item, then re-arm for a new header
        if (last_byte)
        begin
            batch.res[n[IDX_W-1:0]].symbol        = '0;
            batch.res[n[IDX_W-1:0]].symbol_valid  = 1'b0;
            batch.res[n[IDX_W-1:0]].end_of_stream = 1'b1;
            batch.res[n[IDX_W-1:0]].truncated     = !stopped;
            n                    = n + 4'd1;
            awaiting_header_next = 1'b1;
            k_next               = '0;
            in_rem_next          = 1'b0;
            qc_next              = '0;
            acc_next             = '0;
            rem_left_next        = '0;
        end

        batch.count = n;
        batch_push  = accept && (n != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaiting_header_reg <= 1'b1;
            k_reg               <= '0;
            in_rem_reg          <= 1'b0;
            qc_reg              <= '0;
            acc_reg             <= '0;
            rem_left_reg        <= '0;
        end
        else if (accept)
        begin
            awaiting_header_reg <= awaiting_header_next;
            k_reg               <= k_next;
            in_rem_reg          <= in_rem_next;
            qc_reg              <= qc_next;
            acc_reg             <= acc_next;
            rem_left_reg        <= rem_left_next;
        end
    end

endmodule

`default_nettype wire

[src/rsd_batch_fifo.sv]
`default_nettype none

module rsd_batch_fifo (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    wr_en,
    input  rsd_pkg::batch_t        wr_data,
    input  wire                    rd_en,
    output rsd_pkg::batch_t        rd_data,
    output rsd_pkg::fifo_status_t  status
);
    import rsd_pkg::*;

    batch_t     mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign rd_data      = mem_reg[rd_ptr_reg];
    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(wr_en) - 2'(rd_en);
        end
    end

endmodule

`default_nettype wire

[src/rsd_back.sv]
`default_nettype none

module rsd_back (
    input  wire                    clk,
    input  wire                    rst_n,
    input  rsd_pkg::batch_t        batch,
    input  rsd_pkg::fifo_status_t  fifo_status,
    output logic                   batch_pop,
    input  wire                    pop,
    output logic                   empty,
    output logic [7:0]             symbol,
    output logic                   symbol_valid,
    output logic                   end_of_stream,
    output logic                   truncated
);
    import rsd_pkg::*;

    batch_t           cur_reg;
    logic             cur_valid_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             taken;
    logic             batch_done;
    result_t          head;

    assign head          = cur_reg.res[idx_reg];
    assign empty         = !cur_valid_reg;
    assign symbol        = head.symbol;
    assign symbol_valid  = head.symbol_valid;
    assign end_of_stream = head.end_of_stream;
    assign truncated     = head.truncated;

    assign taken      = pop && cur_valid_reg;
    assign batch_done = (CNT_W'(idx_reg) + 4'd1 == cur_reg.count);
    assign batch_pop  = !fifo_status.empty && (!cur_valid_reg || (taken && batch_done));

    always_ff @(posedge clk)
    begin
        if (batch_pop)
        begin
            cur_reg <= batch;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else if (batch_pop)
        begin
            cur_valid_reg <= 1'b1;
            idx_reg       <= '0;
        end
        else if (taken)
        begin
            if (batch_done)
            begin
                cur_valid_reg <= 1'b0;
                idx_reg       <= '0;
            end
            else
            begin
                idx_reg <= idx_reg + 3'd1;
            end
        end
    end

endmodule

`default_nettype wire

[src/rice_stream_decoder.sv]
// Rice stream decoder: push one compressed byte per cycle (bits read lsb first, the first three
// bits of a stream giving k msb first) and pop decoded symbols from the result side, followed by
// one closing item with end_of_stream set after the byte flagged last_byte. A byte is accepted
// every cycle while full is low: all eight bits are decoded combinationally in the front, and
// the items of one byte (up to eight) go as one batch into a two-batch queue. The back hands out
// one item per cycle while pop is high, so a byte yielding n items takes n pops at the result
// side. A batch's items show once it has passed the queue and the back's current-batch register.
`default_nettype none

module rice_stream_decoder (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        push,
    output logic       full,
    input  wire [7:0]  in_byte,
    input  wire        last_byte,
    output logic       empty,
    input  wire        pop,
    output logic [7:0] symbol,
    output logic       symbol_valid,
    output logic       end_of_stream,
    output logic       truncated
);
    import rsd_pkg::*;

    logic         accept;
    logic         batch_push;
    logic         batch_pop;
    batch_t       wr_batch;
    batch_t       rd_batch;
    fifo_status_t fifo_status;

    assign full   = fifo_status.full;
    assign accept = push && !fifo_status.full;

    rsd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .in_byte    (in_byte),
        .last_byte  (last_byte),
        .batch_push (batch_push),
        .batch      (wr_batch)
    );

    rsd_batch_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (batch_push),
        .wr_data (wr_batch),
        .rd_en   (batch_pop),
        .rd_data (rd_batch),
        .status  (fifo_status)
    );

    rsd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .batch         (rd_batch),
        .fifo_status   (fifo_status),
        .batch_pop     (batch_pop),
        .pop           (pop),
        .empty         (empty),
        .symbol        (symbol),
        .symbol_valid  (symbol_valid),
        .end_of_stream (end_of_stream),
        .truncated     (truncated)
    );

    a_kind_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (symbol_valid != end_of_stream))
        else $error("item is neither exactly a symbol nor a closing item");

    a_trunc_on_close: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && symbol_valid) |-> !truncated)
        else $error("truncated set on a symbol item");

    a_close_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && end_of_stream) |-> (symbol == 8'd0))
        else $error("closing item carries a nonzero symbol");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        batch_push |-> (!fifo_status.full && push))
        else $error("batch written into a full queue");

endmodule

`default_nettype wire
